### hdl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

  // Input word width and the number of BCD digits that hold any such word
  localparam int VALUE_W = 32;
  localparam int NCELLS  = 10;
  localparam int BCD_W   = 4;
  localparam int CHAR_W  = 6;

  // ASCII code of '0', cut to the character width
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Per-cycle command shared by every digit cell
  typedef struct packed {
    logic clear;  // zero the digit
    logic conv;   // add-3 adjust, then shift one bit in from below
    logic shift;  // take the whole digit of the lower neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/b2da_cell.sv
// ----------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the double-dabble chain; also shifts digits upward for
// output.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_cell (
  input  wire logic                       clk,
  input  wire b2da_pkg::cell_ctrl_t       ctrl,
  input  wire logic                       carry_in,
  input  wire logic [b2da_pkg::BCD_W-1:0] shift_in,
  output logic      [b2da_pkg::BCD_W-1:0] digit,
  output logic                            carry_out
);

  logic [b2da_pkg::BCD_W-1:0] adj;

  // Add 3 to digits of 5 and up so the next doubling carries correctly
  always_comb begin
    adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry_out = adj[b2da_pkg::BCD_W-1];
  end

  // Hold, clear, double-and-insert, or take the neighbor's digit
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.conv) begin
      digit <= {adj[b2da_pkg::BCD_W-2:0], carry_in};
    end else if (ctrl.shift) begin
      digit <= shift_in;
    end
  end

endmodule

`default_nettype wire

### hdl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned 32-bit binary to decimal ASCII digits, most significant first.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_ready, value        | sink
//  out     | out_valid, out_ready, digit_char,| source
//          | last_digit                       |
//
// One number at a time. Once a number is accepted, the double-dabble pass over
// the ten-cell BCD chain takes one input bit per cycle, then the chain shifts
// out unused leading digits (one per cycle) and emits 1 to MAX_DIGITS digits
// (at most ten), one per cycle when out_ready stays high. Stalls on out only
// hold the emit phase; the output register lets the next number be accepted
// while the last digit waits. Reset (rst, synchronous) returns to idle and
// drops any pending digit.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [b2da_pkg::VALUE_W-1:0] value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [b2da_pkg::CHAR_W-1:0]  digit_char,
  output logic                              last_digit
);

  localparam int NC    = b2da_pkg::NCELLS;
  localparam int KEEP  = (MAX_DIGITS < NC) ? MAX_DIGITS : NC;
  localparam int REM_W = $clog2(NC + 1);
  localparam int CNT_W = $clog2(b2da_pkg::VALUE_W);
  localparam logic [REM_W-1:0] KEEP_R = REM_W'(KEEP);
  localparam logic [REM_W-1:0] REM_ONE = REM_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SCAN, S_EMIT} state_t;

  state_t                        state;
  logic [b2da_pkg::VALUE_W-1:0]  shreg;
  logic [CNT_W-1:0]              cnt;
  logic [REM_W-1:0]              rem;
  logic                          seen;
  b2da_pkg::cell_ctrl_t          ctrl;
  logic [b2da_pkg::BCD_W-1:0]    digit [NC];
  logic                          carry [NC];
  logic [b2da_pkg::BCD_W-1:0]    top;
  logic                          skip;
  logic                          emit_go;

  assign top      = digit[NC-1];
  assign in_ready = (state == S_IDLE);
  assign skip     = (rem > KEEP_R) || ((top == '0) && (rem > REM_ONE) && !seen);
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  // Command for the whole chain this cycle
  always_comb begin
    ctrl.clear = in_valid && in_ready;
    ctrl.conv  = (state == S_CONV);
    ctrl.shift = ((state == S_SCAN) && skip) || emit_go;
  end

  // Chain of digit cells: carries ripple up one cell per cycle during
  // conversion, whole digits move up one cell per cycle during output unless out stalls
  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic                       cin;
    logic [b2da_pkg::BCD_W-1:0] sin;
    if (i == 0) begin : g_first
      assign cin = shreg[b2da_pkg::VALUE_W-1];
      assign sin = '0;
    end else begin : g_rest
      assign cin = carry[i-1];
      assign sin = digit[i-1];
    end
    b2da_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (cin),
      .shift_in  (sin),
      .digit     (digit[i]),
      .carry_out (carry[i])
    );
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      rem       <= '0;
      seen      <= 1'b0;
    end else begin
      // Load the output register on each emitted digit, drop it once taken
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            shreg <= value;
            cnt   <= '1;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          shreg <= shreg << 1;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            rem   <= REM_W'(NC);
            seen  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Drop digits above the kept width and leading zeros
          if (skip) begin
            rem  <= rem - 1'b1;
            seen <= seen || (top != '0);
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            digit_char <= b2da_pkg::ASCII_ZERO + {2'b00, top};
            last_digit <= (rem == REM_ONE);
            rem        <= rem - 1'b1;
            if (rem == REM_ONE) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (rem >= REM_ONE) && (rem <= KEEP_R))
    else $error("emit phase with digit count out of range");

  a_conv_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) && (cnt == '0) |=> (state == S_SCAN) && (rem == REM_W'(NC)))
    else $error("conversion did not hand over to scan");

  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= b2da_pkg::ASCII_ZERO) &&
                  (digit_char <= b2da_pkg::ASCII_ZERO + 6'd9))
    else $error("output character is not a decimal digit");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit_go && (rem == REM_ONE) |=> (state == S_IDLE) && out_valid && last_digit)
    else $error("last digit did not close the run");
`endif

endmodule

`default_nettype wire
